// ===== rtl/rtyw_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB565 tile to YUYV422 writer: shared package
// Field widths, register indexes, color coefficients and the types that pass
// between the tile controller, the pixel lanes and the merge stage.
// ----------------------------------------------------------------------------
package rtyw_pkg;

    // Field widths.
    localparam int unsigned PIX_W   = 16;
    localparam int unsigned ORG_W   = 11;
    localparam int unsigned SIZE_W  = 12;
    localparam int unsigned POS_W   = 13;
    localparam int unsigned OFF_W   = 23;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CIDX_W  = 1;

    // Default tile size limits.
    localparam int unsigned DEF_MAX_WIDTH  = 2048;
    localparam int unsigned DEF_MAX_HEIGHT = 2048;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // Configuration reset values.
    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    // Input mode codes.
    localparam logic MODE_TILE  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    // BT.601 integer coefficients, 18-bit signed.
    localparam int unsigned SUM_W = 18;
    localparam logic signed [SUM_W-1:0] C_YR = 18'sd66;
    localparam logic signed [SUM_W-1:0] C_YG = 18'sd129;
    localparam logic signed [SUM_W-1:0] C_YB = 18'sd25;
    localparam logic signed [SUM_W-1:0] C_UR = -18'sd38;
    localparam logic signed [SUM_W-1:0] C_UG = -18'sd74;
    localparam logic signed [SUM_W-1:0] C_UB = 18'sd112;
    localparam logic signed [SUM_W-1:0] C_VR = 18'sd112;
    localparam logic signed [SUM_W-1:0] C_VG = -18'sd94;
    localparam logic signed [SUM_W-1:0] C_VB = -18'sd18;
    localparam logic signed [SUM_W-1:0] C_ROUND = 18'sd128;
    localparam logic [BYTE_W-1:0] Y_OFFSET = 8'd16;
    localparam logic [BYTE_W-1:0] C_FLIP   = 8'h80;

    // Position of one pixel pair inside the frame.
    typedef struct packed {
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] col;
        logic             last;
    } pos_t;

    // Color result of one lane.
    typedef struct packed {
        logic [BYTE_W-1:0] luma;
        logic [BYTE_W-1:0] cb;
        logic [BYTE_W-1:0] cr;
    } yuv_t;

endpackage

// ===== rtl/rtyw_lane.sv =====
// ----------------------------------------------------------------------------
// RGB565 tile to YUYV422 writer: pixel lane
// Converts one RGB565 pixel into BT.601 Y, U and V bytes. Purely
// combinational; the merge stage registers the result.
// ----------------------------------------------------------------------------
module rtyw_lane (
    input  logic [rtyw_pkg::PIX_W-1:0] pixel,
    output rtyw_pkg::yuv_t             yuv
);
    import rtyw_pkg::*;

    logic signed [SUM_W-1:0] r_s;
    logic signed [SUM_W-1:0] g_s;
    logic signed [SUM_W-1:0] b_s;
    logic signed [SUM_W-1:0] y_sum;
    logic signed [SUM_W-1:0] u_sum;
    logic signed [SUM_W-1:0] v_sum;

    // Expand the 5/6/5 components to 8-bit scale, zero-extended.
    assign r_s = signed'({10'd0, pixel[15:11], 3'd0});
    assign g_s = signed'({10'd0, pixel[10:5], 2'd0});
    assign b_s = signed'({10'd0, pixel[4:0], 3'd0});

    // Weighted sums with rounding bias.
    assign y_sum = C_YR * r_s + C_YG * g_s + C_YB * b_s + C_ROUND;
    assign u_sum = C_UR * r_s + C_UG * g_s + C_UB * b_s + C_ROUND;
    assign v_sum = C_VR * r_s + C_VG * g_s + C_VB * b_s + C_ROUND;

    // Floor shift by eight keeps bits 15:8; adding 128 to a byte flips its top bit.
    assign yuv.luma = y_sum[15:8] + Y_OFFSET;
    assign yuv.cb   = u_sum[15:8] ^ C_FLIP;
    assign yuv.cr   = v_sum[15:8] ^ C_FLIP;

endmodule

// ===== rtl/rtyw_tile_ctrl.sv =====
// ----------------------------------------------------------------------------
// RGB565 tile to YUYV422 writer: tile controller
// Holds the tile geometry and the row and column counters, walks each row
// two pixels at a time, and fills the first pipeline stage with the pixel
// pair and its frame position.
// ----------------------------------------------------------------------------
module rtyw_tile_ctrl #(
    parameter int unsigned MAX_WIDTH  = rtyw_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = rtyw_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic                        s_valid,
    input  logic                        s_mode,
    input  logic [rtyw_pkg::ORG_W-1:0]  s_tile_x,
    input  logic [rtyw_pkg::ORG_W-1:0]  s_tile_y,
    input  logic [rtyw_pkg::SIZE_W-1:0] s_tile_width,
    input  logic [rtyw_pkg::SIZE_W-1:0] s_tile_height,
    input  logic [rtyw_pkg::PIX_W-1:0]  s_pixel_a,
    input  logic [rtyw_pkg::PIX_W-1:0]  s_pixel_b,
    output logic                        st_valid,
    output rtyw_pkg::pos_t              st_pos,
    output logic [rtyw_pkg::PIX_W-1:0]  st_pixel_a,
    output logic [rtyw_pkg::PIX_W-1:0]  st_pixel_b
);
    import rtyw_pkg::*;

    logic              tile_active_reg, tile_active_next;
    logic [ORG_W-1:0]  origin_col_reg, origin_col_next;
    logic [ORG_W-1:0]  origin_line_reg, origin_line_next;
    logic [SIZE_W-1:0] span_cols_reg, span_cols_next;
    logic [SIZE_W-1:0] span_lines_reg, span_lines_next;
    logic [SIZE_W-1:0] col_count_reg, col_count_next;
    logic [SIZE_W-1:0] line_count_reg, line_count_next;

    logic              st_valid_reg, st_valid_next;
    pos_t              st_pos_reg;
    logic [PIX_W-1:0]  st_pixel_a_reg;
    logic [PIX_W-1:0]  st_pixel_b_reg;

    logic              accept;
    logic              pixel_hit;
    logic [SIZE_W-1:0] w_sat;
    logic [SIZE_W-1:0] h_sat;
    logic              odd_end;
    logic              row_done;
    logic              last_pair;
    pos_t              pos;

    assign accept    = s_valid && advance;
    assign pixel_hit = accept && (s_mode == MODE_PIXEL) && tile_active_reg;

    // Clamp the requested tile size to the configured maximum.
    assign w_sat = (32'(s_tile_width) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : s_tile_width;
    assign h_sat = (32'(s_tile_height) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : s_tile_height;

    // Row walk decisions for the current pair.
    assign odd_end   = ({1'b0, col_count_reg} + 13'd1) >= {1'b0, span_cols_reg};
    assign row_done  = ({1'b0, col_count_reg} + 13'd2) >= {1'b0, span_cols_reg};
    assign last_pair = row_done &&
                       (({1'b0, line_count_reg} + 13'd1) >= {1'b0, span_lines_reg});

    // Frame position of the current pair.
    assign pos.line = {2'd0, origin_line_reg} + {1'b0, line_count_reg};
    assign pos.col  = {2'd0, origin_col_reg} + {1'b0, col_count_reg};
    assign pos.last = last_pair;

    // Tile state update on each accepted request.
    always_comb begin
        tile_active_next = tile_active_reg;
        origin_col_next  = origin_col_reg;
        origin_line_next = origin_line_reg;
        span_cols_next   = span_cols_reg;
        span_lines_next  = span_lines_reg;
        col_count_next   = col_count_reg;
        line_count_next  = line_count_reg;
        if (accept && (s_mode == MODE_TILE)) begin
            origin_col_next  = s_tile_x;
            origin_line_next = s_tile_y;
            span_cols_next   = w_sat;
            span_lines_next  = h_sat;
            col_count_next   = '0;
            line_count_next  = '0;
            tile_active_next = (w_sat != '0) && (h_sat != '0);
        end else if (pixel_hit) begin
            if (row_done) begin
                col_count_next = '0;
                if (last_pair) begin
                    tile_active_next = 1'b0;
                    line_count_next  = '0;
                end else begin
                    line_count_next = line_count_reg + 12'd1;
                end
            end else begin
                col_count_next = col_count_reg + 12'd2;
            end
        end
    end

    // The stage register moves only when the output side can take its content.
    assign st_valid_next = advance ? pixel_hit : st_valid_reg;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_active_reg <= 1'b0;
            origin_col_reg  <= '0;
            origin_line_reg <= '0;
            span_cols_reg   <= '0;
            span_lines_reg  <= '0;
            col_count_reg   <= '0;
            line_count_reg  <= '0;
            st_valid_reg    <= 1'b0;
        end else begin
            tile_active_reg <= tile_active_next;
            origin_col_reg  <= origin_col_next;
            origin_line_reg <= origin_line_next;
            span_cols_reg   <= span_cols_next;
            span_lines_reg  <= span_lines_next;
            col_count_reg   <= col_count_next;
            line_count_reg  <= line_count_next;
            st_valid_reg    <= st_valid_next;
        end
    end

    // Stage payload; the second pixel is replaced at an odd row end.
    always_ff @(posedge aclk) begin
        if (advance && pixel_hit) begin
            st_pos_reg     <= pos;
            st_pixel_a_reg <= s_pixel_a;
            st_pixel_b_reg <= odd_end ? s_pixel_a : s_pixel_b;
        end
    end

    assign st_valid   = st_valid_reg;
    assign st_pos     = st_pos_reg;
    assign st_pixel_a = st_pixel_a_reg;
    assign st_pixel_b = st_pixel_b_reg;

`ifndef SYNTHESIS
    // The column counter stays inside the tile row while a tile is active.
    a_col_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        tile_active_reg |-> (col_count_reg < span_cols_reg))
        else $error("column counter outside the tile row");

    // The line counter stays inside the tile while a tile is active.
    a_line_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        tile_active_reg |-> (line_count_reg < span_lines_reg))
        else $error("line counter outside the tile");

    // Pairs always start on an even column.
    a_col_even: assert property (@(posedge aclk) disable iff (!aresetn)
        !col_count_reg[0])
        else $error("column counter is odd");

    // The final pair of a tile leaves no tile active.
    a_last_ends_tile: assert property (@(posedge aclk) disable iff (!aresetn)
        (pixel_hit && last_pair) |=> !tile_active_reg)
        else $error("tile still active after its last pair");
`endif

endmodule

// ===== rtl/rtyw_merge.sv =====
// ----------------------------------------------------------------------------
// RGB565 tile to YUYV422 writer: merge stage
// Combines the two lane results into one YUYV group, computes the frame
// buffer byte offset and the out-of-frame flag, and holds the result
// register of the output channel.
// ----------------------------------------------------------------------------
module rtyw_merge (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic                        st_valid,
    input  rtyw_pkg::pos_t              st_pos,
    input  rtyw_pkg::yuv_t              lane_a,
    input  rtyw_pkg::yuv_t              lane_b,
    input  logic [rtyw_pkg::SIZE_W-1:0] frame_width,
    input  logic [rtyw_pkg::SIZE_W-1:0] frame_height,
    output logic                        m_valid,
    output logic [rtyw_pkg::OFF_W-1:0]  m_byte_offset,
    output logic [rtyw_pkg::BYTE_W-1:0] m_luma_first,
    output logic [rtyw_pkg::BYTE_W-1:0] m_chroma_blue,
    output logic [rtyw_pkg::BYTE_W-1:0] m_luma_second,
    output logic [rtyw_pkg::BYTE_W-1:0] m_chroma_red,
    output logic                        m_last_of_tile,
    output logic                        m_out_of_frame
);
    import rtyw_pkg::*;

    localparam int unsigned PROD_W = POS_W + SIZE_W;

    logic              m_valid_reg, m_valid_next;
    logic [OFF_W-1:0]  offset_reg;
    logic [BYTE_W-1:0] luma_first_reg;
    logic [BYTE_W-1:0] chroma_blue_reg;
    logic [BYTE_W-1:0] luma_second_reg;
    logic [BYTE_W-1:0] chroma_red_reg;
    logic              last_reg;
    logic              oof_reg;

    logic [PROD_W-1:0] line_base;
    logic [PROD_W-1:0] pixel_index;
    logic              oof;

    // Pixel index = line * frame_width + column; the byte offset is twice that.
    assign line_base   = PROD_W'(st_pos.line) * PROD_W'(frame_width);
    assign pixel_index = line_base + PROD_W'(st_pos.col);

    // Outside the frame when either coordinate reaches the frame size.
    assign oof = (st_pos.col >= {1'b0, frame_width}) ||
                 (st_pos.line >= {1'b0, frame_height});

    assign m_valid_next = advance ? st_valid : m_valid_reg;

    // Output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload: chroma comes from the first pixel only.
    always_ff @(posedge aclk) begin
        if (advance && st_valid) begin
            offset_reg      <= {pixel_index[OFF_W-2:0], 1'b0};
            luma_first_reg  <= lane_a.luma;
            chroma_blue_reg <= lane_a.cb;
            luma_second_reg <= lane_b.luma;
            chroma_red_reg  <= lane_a.cr;
            last_reg        <= st_pos.last;
            oof_reg         <= oof;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_byte_offset  = offset_reg;
    assign m_luma_first   = luma_first_reg;
    assign m_chroma_blue  = chroma_blue_reg;
    assign m_luma_second  = luma_second_reg;
    assign m_chroma_red   = chroma_red_reg;
    assign m_last_of_tile = last_reg;
    assign m_out_of_frame = oof_reg;

endmodule

// ===== rtl/rgb565_tile_to_yuyv422_writer_core.sv =====
// ----------------------------------------------------------------------------
// RGB565 tile to YUYV422 writer: top level
// Tile-start requests set the tile geometry; each pixel request of an active
// tile yields one YUYV group with its frame buffer byte offset.
// ----------------------------------------------------------------------------
// The block takes one request per clock and keeps that rate while results
// are taken each cycle; an accepted pixel pair passes the tile controller
// stage and then the result register, where two color lanes and one
// 13 x 12 bit offset multiplier finish the work, on its way to the result
// channel. Tile-start requests and pixel requests without an active tile
// produce no result. When the result register is full and not taken, the
// whole pipeline holds and s_ready drops. Frame size registers are written
// through the cfg channel, which is always ready, and should be changed
// only while no pixel pair is in flight.
module rgb565_tile_to_yuyv422_writer_core #(
    parameter int unsigned MAX_WIDTH  = rtyw_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = rtyw_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration channel.
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rtyw_pkg::CIDX_W-1:0] cfg_index,
    input  logic [rtyw_pkg::SIZE_W-1:0] cfg_data,
    // Input channel.
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_mode,
    input  logic [rtyw_pkg::ORG_W-1:0]  s_tile_x,
    input  logic [rtyw_pkg::ORG_W-1:0]  s_tile_y,
    input  logic [rtyw_pkg::SIZE_W-1:0] s_tile_width,
    input  logic [rtyw_pkg::SIZE_W-1:0] s_tile_height,
    input  logic [rtyw_pkg::PIX_W-1:0]  s_pixel_a,
    input  logic [rtyw_pkg::PIX_W-1:0]  s_pixel_b,
    // Result channel.
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rtyw_pkg::OFF_W-1:0]  m_byte_offset,
    output logic [rtyw_pkg::BYTE_W-1:0] m_luma_first,
    output logic [rtyw_pkg::BYTE_W-1:0] m_chroma_blue,
    output logic [rtyw_pkg::BYTE_W-1:0] m_luma_second,
    output logic [rtyw_pkg::BYTE_W-1:0] m_chroma_red,
    output logic                        m_last_of_tile,
    output logic                        m_out_of_frame
);
    import rtyw_pkg::*;

    logic [SIZE_W-1:0] frame_width_reg, frame_width_next;
    logic [SIZE_W-1:0] frame_height_reg, frame_height_next;

    logic             advance;
    logic             st_valid;
    pos_t             st_pos;
    logic [PIX_W-1:0] st_pixel_a;
    logic [PIX_W-1:0] st_pixel_b;
    yuv_t             lane_a;
    yuv_t             lane_b;

    // The pipeline moves whenever the result register is empty or being taken.
    assign advance   = !m_valid || m_ready;
    assign s_ready   = advance;
    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                REG_FRAME_HEIGHT: frame_height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    // Tile geometry, counters and first pipeline stage.
    rtyw_tile_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_tile_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .s_valid       (s_valid),
        .s_mode        (s_mode),
        .s_tile_x      (s_tile_x),
        .s_tile_y      (s_tile_y),
        .s_tile_width  (s_tile_width),
        .s_tile_height (s_tile_height),
        .s_pixel_a     (s_pixel_a),
        .s_pixel_b     (s_pixel_b),
        .st_valid      (st_valid),
        .st_pos        (st_pos),
        .st_pixel_a    (st_pixel_a),
        .st_pixel_b    (st_pixel_b)
    );

    // One color lane per pixel of the pair.
    rtyw_lane u_lane_a (
        .pixel (st_pixel_a),
        .yuv   (lane_a)
    );

    rtyw_lane u_lane_b (
        .pixel (st_pixel_b),
        .yuv   (lane_b)
    );

    // Merge lanes, compute the offset and hold the result.
    rtyw_merge u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .st_valid       (st_valid),
        .st_pos         (st_pos),
        .lane_a         (lane_a),
        .lane_b         (lane_b),
        .frame_width    (frame_width_reg),
        .frame_height   (frame_height_reg),
        .m_valid        (m_valid),
        .m_byte_offset  (m_byte_offset),
        .m_luma_first   (m_luma_first),
        .m_chroma_blue  (m_chroma_blue),
        .m_luma_second  (m_luma_second),
        .m_chroma_red   (m_chroma_red),
        .m_last_of_tile (m_last_of_tile),
        .m_out_of_frame (m_out_of_frame)
    );

endmodule

// ===== bench/yuyv_group_checker.sv =====
// ----------------------------------------------------------------------------
// YUYV group checker for the RGB565 tile to YUYV422 writer
// Watches the configuration, request and result channels, keeps its own copy
// of the frame size and tile walk, predicts every YUYV group and compares
// each result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module yuyv_group_checker #(
    parameter int unsigned MAX_WIDTH  = rtyw_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = rtyw_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [rtyw_pkg::CIDX_W-1:0] cfg_index,
    input  logic [rtyw_pkg::SIZE_W-1:0] cfg_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        s_mode,
    input  logic [rtyw_pkg::ORG_W-1:0]  s_tile_x,
    input  logic [rtyw_pkg::ORG_W-1:0]  s_tile_y,
    input  logic [rtyw_pkg::SIZE_W-1:0] s_tile_width,
    input  logic [rtyw_pkg::SIZE_W-1:0] s_tile_height,
    input  logic [rtyw_pkg::PIX_W-1:0]  s_pixel_a,
    input  logic [rtyw_pkg::PIX_W-1:0]  s_pixel_b,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [rtyw_pkg::OFF_W-1:0]  m_byte_offset,
    input  logic [rtyw_pkg::BYTE_W-1:0] m_luma_first,
    input  logic [rtyw_pkg::BYTE_W-1:0] m_chroma_blue,
    input  logic [rtyw_pkg::BYTE_W-1:0] m_luma_second,
    input  logic [rtyw_pkg::BYTE_W-1:0] m_chroma_red,
    input  logic                        m_last_of_tile,
    input  logic                        m_out_of_frame,
    output int unsigned                 fail_count,
    output int unsigned                 pending_count
);
    import rtyw_pkg::*;

    // One YUYV group as it leaves the block.
    typedef struct packed {
        logic [OFF_W-1:0]  byte_offset;
        logic [BYTE_W-1:0] luma_first;
        logic [BYTE_W-1:0] chroma_blue;
        logic [BYTE_W-1:0] luma_second;
        logic [BYTE_W-1:0] chroma_red;
        logic              last_of_tile;
        logic              out_of_frame;
    } yuyv_group_t;

    yuyv_group_t expected_groups[$];

    // Frame size registers.
    logic [SIZE_W-1:0] frame_w;
    logic [SIZE_W-1:0] frame_h;

    // Tile walk state.
    logic              tile_on;
    logic [ORG_W-1:0]  org_col;
    logic [ORG_W-1:0]  org_line;
    int unsigned       span_w;
    int unsigned       span_h;
    int unsigned       col_idx;
    int unsigned       line_idx;

    // BT.601 luma of one RGB565 pixel.
    function automatic logic [BYTE_W-1:0] luma565(input logic [PIX_W-1:0] p);
        int pw, r, g, b, s;
        pw = {16'd0, p};
        r = (pw >> 8) & 'hF8;
        g = (pw >> 3) & 'hFC;
        b = (pw << 3) & 'hF8;
        s = 66 * r + 129 * g + 25 * b + 128;
        s = (s >>> 8) + 16;
        return s[BYTE_W-1:0];
    endfunction

    // BT.601 chroma of one RGB565 pixel; the shift floors negative sums.
    function automatic logic [BYTE_W-1:0] chroma565(input logic [PIX_W-1:0] p,
                                                   input int kr, input int kg,
                                                   input int kb);
        int pw, r, g, b, s;
        pw = {16'd0, p};
        r = (pw >> 8) & 'hF8;
        g = (pw >> 3) & 'hFC;
        b = (pw << 3) & 'hF8;
        s = kr * r + kg * g + kb * b + 128;
        s = (s >>> 8) + 128;
        return s[BYTE_W-1:0];
    endfunction

    // A tile-start request drops any open tile and loads the new geometry.
    task automatic open_tile(input logic [ORG_W-1:0] x, input logic [ORG_W-1:0] y,
                             input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        org_col  = x;
        org_line = y;
        span_w   = (32'(w) > MAX_WIDTH) ? MAX_WIDTH : 32'(w);
        span_h   = (32'(h) > MAX_HEIGHT) ? MAX_HEIGHT : 32'(h);
        col_idx  = 0;
        line_idx = 0;
        tile_on  = (span_w != 0) && (span_h != 0);
    endtask

    // Predict the group for one pixel pair and step along the tile.
    task automatic predict_pair(input logic [PIX_W-1:0] pa, input logic [PIX_W-1:0] pb);
        yuyv_group_t      grp;
        logic [PIX_W-1:0] second;
        int unsigned      line, col;
        longint unsigned  off;
        bit               row_done;
        second = (col_idx + 1 >= span_w) ? pa : pb;
        line   = 32'(org_line) + line_idx;
        col    = 32'(org_col) + col_idx;
        off    = 64'(line);
        off    = off * 64'(frame_w) * 64'd2 + 64'(col) * 64'd2;
        row_done = (col_idx + 2 >= span_w);
        grp.byte_offset  = off[OFF_W-1:0];
        grp.luma_first   = luma565(pa);
        grp.chroma_blue  = chroma565(pa, -38, -74, 112);
        grp.luma_second  = luma565(second);
        grp.chroma_red   = chroma565(pa, 112, -94, -18);
        grp.last_of_tile = row_done && (line_idx + 1 >= span_h);
        grp.out_of_frame = (col >= 32'(frame_w)) || (line >= 32'(frame_h));
        expected_groups.push_back(grp);
        if (row_done) begin
            col_idx  = 0;
            line_idx = line_idx + 1;
            if (grp.last_of_tile) begin
                tile_on  = 1'b0;
                line_idx = 0;
            end
        end else begin
            col_idx = col_idx + 2;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Results are compared before new requests are predicted; a request
    // never comes out in the cycle it is accepted.
    always @(posedge aclk) begin : watch
        yuyv_group_t seen, want;
        if (!aresetn) begin
            frame_w = FRAME_WIDTH_RST;
            frame_h = FRAME_HEIGHT_RST;
            open_tile('0, '0, '0, '0);
            expected_groups.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                seen = {m_byte_offset, m_luma_first, m_chroma_blue, m_luma_second,
                        m_chroma_red, m_last_of_tile, m_out_of_frame};
                if (expected_groups.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual offset %0d",
                             $time, seen.byte_offset);
                    fail_count++;
                end else begin
                    want = expected_groups.pop_front();
                    check_field("byte_offset", 32'(want.byte_offset),
                                32'(seen.byte_offset));
                    check_field("luma_first", 32'(want.luma_first), 32'(seen.luma_first));
                    check_field("chroma_blue", 32'(want.chroma_blue),
                                32'(seen.chroma_blue));
                    check_field("luma_second", 32'(want.luma_second),
                                32'(seen.luma_second));
                    check_field("chroma_red", 32'(want.chroma_red), 32'(seen.chroma_red));
                    check_field("last_of_tile", 32'(want.last_of_tile),
                                32'(seen.last_of_tile));
                    check_field("out_of_frame", 32'(want.out_of_frame),
                                32'(seen.out_of_frame));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FRAME_WIDTH: begin
                        frame_w = cfg_data;
                    end
                    REG_FRAME_HEIGHT: begin
                        frame_h = cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_mode == MODE_TILE) begin
                    open_tile(s_tile_x, s_tile_y, s_tile_width, s_tile_height);
                end else if (tile_on) begin
                    predict_pair(s_pixel_a, s_pixel_b);
                end
            end
        end
        pending_count = expected_groups.size();
    end

endmodule

// ===== bench/tb_rgb565_tile_to_yuyv422_writer_core.sv =====
// ----------------------------------------------------------------------------
// Testbench for the RGB565 tile to YUYV422 writer core
// Drives a directed set of tiles and pixel pairs, then random tile traffic
// under several frame sizes and idle patterns, including a long result stall;
// the group checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_rgb565_tile_to_yuyv422_writer_core;
    import rtyw_pkg::*;

    localparam int unsigned CLK_PERIOD   = 12;
    localparam int unsigned RESET_CYCLES = 11;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES  = 120;
    localparam int unsigned PHASE_ITEMS  = 120;
    localparam int unsigned RUN_CYCLES   = 600000;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index     = '0;
    logic [SIZE_W-1:0]  cfg_data      = '0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic               s_mode        = MODE_TILE;
    logic [ORG_W-1:0]   s_tile_x      = '0;
    logic [ORG_W-1:0]   s_tile_y      = '0;
    logic [SIZE_W-1:0]  s_tile_width  = '0;
    logic [SIZE_W-1:0]  s_tile_height = '0;
    logic [PIX_W-1:0]   s_pixel_a     = '0;
    logic [PIX_W-1:0]   s_pixel_b     = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic [OFF_W-1:0]   m_byte_offset;
    logic [BYTE_W-1:0]  m_luma_first;
    logic [BYTE_W-1:0]  m_chroma_blue;
    logic [BYTE_W-1:0]  m_luma_second;
    logic [BYTE_W-1:0]  m_chroma_red;
    logic               m_last_of_tile;
    logic               m_out_of_frame;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_tag      = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned fail_count;
    int unsigned pending_count;

    rgb565_tile_to_yuyv422_writer_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_tile_x       (s_tile_x),
        .s_tile_y       (s_tile_y),
        .s_tile_width   (s_tile_width),
        .s_tile_height  (s_tile_height),
        .s_pixel_a      (s_pixel_a),
        .s_pixel_b      (s_pixel_b),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_offset  (m_byte_offset),
        .m_luma_first   (m_luma_first),
        .m_chroma_blue  (m_chroma_blue),
        .m_luma_second  (m_luma_second),
        .m_chroma_red   (m_chroma_red),
        .m_last_of_tile (m_last_of_tile),
        .m_out_of_frame (m_out_of_frame)
    );

    yuyv_group_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_tile_x       (s_tile_x),
        .s_tile_y       (s_tile_y),
        .s_tile_width   (s_tile_width),
        .s_tile_height  (s_tile_height),
        .s_pixel_a      (s_pixel_a),
        .s_pixel_b      (s_pixel_b),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_offset  (m_byte_offset),
        .m_luma_first   (m_luma_first),
        .m_chroma_blue  (m_chroma_blue),
        .m_luma_second  (m_luma_second),
        .m_chroma_red   (m_chroma_red),
        .m_last_of_tile (m_last_of_tile),
        .m_out_of_frame (m_out_of_frame),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    // Clock.
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Result side: random stalls, plus one long hold-off whenever a new one
    // is requested by the stimulus.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_seen != hold_tag) begin
            hold_seen = hold_tag;
            hold_left = HOLD_CYCLES - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Mostly random pixels, with pure colors and the extremes mixed in.
    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(15))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'hF800;
            3: return 16'h07E0;
            4: return 16'h001F;
            default: return PIX_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // Offer one request, with random idle cycles first; returns on the edge
    // at which it is accepted.
    task automatic send_request(input logic mode, input logic [ORG_W-1:0] x,
                                input logic [ORG_W-1:0] y, input logic [SIZE_W-1:0] w,
                                input logic [SIZE_W-1:0] h, input logic [PIX_W-1:0] pa,
                                input logic [PIX_W-1:0] pb);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_tile_x      <= x;
        s_tile_y      <= y;
        s_tile_width  <= w;
        s_tile_height <= h;
        s_pixel_a     <= pa;
        s_pixel_b     <= pb;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_tile(input int unsigned x, input int unsigned y,
                             input int unsigned w, input int unsigned h);
        send_request(MODE_TILE, ORG_W'(x), ORG_W'(y), SIZE_W'(w), SIZE_W'(h),
                     PIX_W'($urandom_range(16'hFFFF)), PIX_W'($urandom_range(16'hFFFF)));
    endtask

    task automatic send_pair(input logic [PIX_W-1:0] pa, input logic [PIX_W-1:0] pb);
        send_request(MODE_PIXEL, ORG_W'($urandom_range(2047)), ORG_W'($urandom_range(2047)),
                     SIZE_W'($urandom_range(4095)), SIZE_W'($urandom_range(4095)), pa, pb);
    endtask

    // Write both frame size registers back to back, valid held high between.
    task automatic set_frame(input logic [SIZE_W-1:0] fw, input logic [SIZE_W-1:0] fh);
        cfg_valid <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= fw;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= fh;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering, wait for every predicted group, then let the pipeline
    // settle so that no dropped request is still in flight.
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Random tile traffic: mostly complete tiles, the rest broken tiles,
    // stray pixel pairs and empty or oversize tiles.
    task automatic random_traffic(input int unsigned target);
        int unsigned sent, pick, x, y, w, h, pairs, n;
        sent = 0;
        while (sent < target) begin
            pick = $urandom_range(99);
            x = $urandom_range(1) ? $urandom_range(2047) : $urandom_range(63);
            y = $urandom_range(1) ? $urandom_range(2047) : $urandom_range(63);
            w = ($urandom_range(9) == 0) ? $urandom_range(10, 48) : $urandom_range(1, 8);
            h = $urandom_range(1, 4);
            pairs = ((w + 1) / 2) * h;
            if (pick < 72) begin
                n = pairs;
            end else if (pick < 84) begin
                n = $urandom_range(pairs - 1);
            end else if (pick < 92) begin
                n = 0;
            end else begin
                w = $urandom_range(4095);
                h = $urandom_range(4095);
                if ($urandom_range(3) == 0) begin
                    if ($urandom_range(1)) w = 0; else h = 0;
                end
                n = $urandom_range(3);
            end
            if (pick < 84 || pick >= 92) begin
                send_tile(x, y, w, h);
                sent++;
            end else begin
                n = $urandom_range(1, 2);
            end
            repeat (n) begin
                send_pair(pick_pixel(), pick_pixel());
                sent++;
            end
        end
    endtask

    task automatic run_phase(input logic [SIZE_W-1:0] fw, input logic [SIZE_W-1:0] fh,
                             input int unsigned snd_pct, input int unsigned rcv_pct,
                             input bit long_hold);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        set_frame(fw, fh);
        if (long_hold) hold_tag++;
        random_traffic(PHASE_ITEMS);
        drain();
    endtask

    initial begin : stimulus
        send_idle_pct = 35;
        recv_idle_pct = 61;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset frame size. A pair with no tile open.
        send_pair(16'hFFFF, 16'h0000);
        // Odd-width tile: each row ends on a lone pixel.
        send_tile(0, 0, 3, 2);
        send_pair(16'h0000, 16'hFFFF);
        send_pair(16'hF800, 16'h07E0);
        send_pair(16'h001F, 16'hFFFF);
        send_pair(16'hFFFF, 16'h1234);
        // The tile has ended, so this pair is dropped.
        send_pair(16'h07E0, 16'h001F);
        // Empty tiles in either dimension.
        send_tile(7, 9, 0, 5);
        send_pair(16'h1234, 16'h5678);
        send_tile(7, 9, 5, 0);
        send_pair(16'h8765, 16'h4321);
        // Origin at the far corner lies outside the frame.
        send_tile(2047, 2047, 2, 1);
        send_pair(16'hF81F, 16'h07FF);
        // A new tile start drops a tile that is partly done.
        send_tile(10, 5, 4, 2);
        send_pair(16'hAAAA, 16'h5555);
        send_tile(0, 1, 1, 1);
        send_pair(16'h5555, 16'hAAAA);
        // Oversize tile clamps to the maximum size.
        send_tile(3, 3, 4095, 4095);
        send_pair(16'hFFE0, 16'h001F);
        send_pair(16'h0000, 16'hF800);
        drain();

        // Random phases over the frame size extremes and idle patterns.
        run_phase(12'd4095, 12'd4095, 35, 61, 1'b0);
        run_phase(12'd0, 12'd0, 35, 61, 1'b0);
        run_phase(12'd1, 12'd1, 61, 35, 1'b0);
        run_phase(12'd2048, 12'd2048, 61, 35, 1'b0);
        run_phase(SIZE_W'($urandom_range(1, 4095)), SIZE_W'($urandom_range(1, 4095)),
                  0, 0, 1'b1);
        run_phase(12'd640, 12'd480, 0, 0, 1'b0);

        // A full-width oversize row: the clamp shows in where the tile ends.
        send_tile($urandom_range(2047), $urandom_range(2047), 4095, 1);
        repeat (1024) send_pair(pick_pixel(), pick_pixel());
        drain();

        if (fail_count == 0) begin
            $display("tb_rgb565_tile_to_yuyv422_writer_core: clean");
        end else begin
            $display("tb_rgb565_tile_to_yuyv422_writer_core: errors");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #(CLK_PERIOD * RUN_CYCLES);
        $display("tb_rgb565_tile_to_yuyv422_writer_core: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rtyw_pkg.sv
rtl/rtyw_lane.sv
rtl/rtyw_tile_ctrl.sv
rtl/rtyw_merge.sv
rtl/rgb565_tile_to_yuyv422_writer_core.sv
bench/yuyv_group_checker.sv
bench/tb_rgb565_tile_to_yuyv422_writer_core.sv
